[src/stc_pkg.sv]
package stc_pkg;

    localparam int SUM_W     = 19;
    localparam int COUNT_W   = 16;
    localparam int OVER_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT  = 2'd1;

    // step direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // status codes
    localparam logic [2:0] STAT_IDLE   = 3'd0;
    localparam logic [2:0] STAT_BUSY   = 3'd1;
    localparam logic [2:0] STAT_DONE   = 3'd2;
    localparam logic [2:0] STAT_TOPERR = 3'd3;
    localparam logic [2:0] STAT_BOTERR = 3'd4;

    localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET = 16'd20000;
    localparam logic [OVER_W-1:0]  OVERSHOOT_RESET  = 8'd20;

    typedef struct packed {
        logic start_request;
        logic top_hit;
        logic bottom_hit;
    } tick_in_t;

    typedef struct packed {
        logic [1:0]         step_dir;
        logic [2:0]         phase;
        logic [2:0]         status;
        logic               calibrated;
        logic [COUNT_W-1:0] average_count;
    } tick_out_t;

endpackage

[src/stepper_travel_calibrator.sv]
// channel   ports                          transfer
// -------   ----------------------------   -------------------------------------
// input     s_valid, s_ready, s_data       one step tick per transfer
// result    m_valid, m_ready, m_data       one result per input tick, in order
// config    cfg_wen, cfg_index, cfg_wdata  register write on any edge with cfg_wen
//
// one tick per cycle while s_ready is high: the sequencer updates on the input
// transfer and its result is registered on the same edge
// an output register plus a skid register keep s_ready high while one result waits;
// s_ready drops only while both of them hold a result
// reset (aresetn, synchronous, active low) returns the sequencer to idle and empties
// the output stage; register defaults are step limit 20000 and overshoot 20 steps
module stepper_travel_calibrator #(
    parameter int PHASES = 8,
    parameter int ROUNDS = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  stc_pkg::tick_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output stc_pkg::tick_out_t                  m_data,
    input  logic                                cfg_wen,
    input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UP     = 3'd1;
    localparam logic [2:0] ST_DOWN   = 3'd2;
    localparam logic [2:0] ST_RETURN = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;
    localparam logic [2:0] ST_TOPERR = 3'd6;
    localparam logic [2:0] ST_BOTERR = 3'd7;

    localparam int SW = stc_pkg::SUM_W;
    localparam int CW = stc_pkg::COUNT_W;
    localparam int OW = stc_pkg::OVER_W;

    // reciprocal for exact floor division of a SW-bit sum by ROUNDS (up to 8)
    localparam int RECIP_SHIFT = SW + 3;
    localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + ROUNDS - 1) / ROUNDS;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int PROD_W = SW + RECIP_W;

    localparam logic [2:0] PHASE_LAST = 3'(PHASES - 1);
    localparam logic [2:0] ROUND_LAST = 3'(ROUNDS - 1);

    logic [CW-1:0] travel_limit_reg;
    logic [OW-1:0] overshoot_steps_reg;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] step_cnt_reg, step_cnt_next;
    logic [2:0]    round_reg, round_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] avg_reg, avg_next;
    logic [OW-1:0] over_cnt_reg, over_cnt_next;
    logic          done_reg, done_next;
    logic [1:0]    dir;
    logic [2:0]    status;

    logic [2:0]    phase_up, phase_down;
    logic          step_limit;
    logic [PROD_W-1:0] avg_prod;

    stc_pkg::tick_out_t result;
    stc_pkg::tick_out_t out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               in_xfer, out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = out_valid_reg && m_ready;
    assign s_ready  = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_limit_reg    <= stc_pkg::STEP_LIMIT_RESET;
            overshoot_steps_reg <= stc_pkg::OVERSHOOT_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                stc_pkg::CFG_STEP_LIMIT: travel_limit_reg <= cfg_wdata;
                stc_pkg::CFG_OVERSHOOT:  overshoot_steps_reg <= cfg_wdata[OW-1:0];
                default: ;
            endcase
        end
    end

    assign phase_up   = (({1'b0, phase_reg} + 4'd1) >= 4'(PHASES)) ? 3'd0 : phase_reg + 3'd1;
    assign phase_down = ((phase_reg == 3'd0) || ({1'b0, phase_reg} >= 4'(PHASES)))
                        ? PHASE_LAST : phase_reg - 3'd1;
    assign step_limit = step_cnt_reg >= travel_limit_reg;
    assign avg_prod   = PROD_W'(sum_reg) * PROD_W'(RECIP);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        step_cnt_next = step_cnt_reg;
        round_next    = round_reg;
        sum_next      = sum_reg;
        avg_next      = avg_reg;
        over_cnt_next = over_cnt_reg;
        done_next     = done_reg;
        dir           = stc_pkg::DIR_NONE;

        unique case (state_reg)
            ST_UP: begin
                if (step_limit) begin
                    state_next = ST_TOPERR;
                end else if (s_data.top_hit) begin
                    step_cnt_next = '0;
                    state_next    = ST_DOWN;
                end else begin
                    phase_next    = phase_up;
                    dir           = stc_pkg::DIR_UP;
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_DOWN: begin
                if (step_limit) begin
                    state_next = ST_BOTERR;
                end else if (s_data.bottom_hit) begin
                    sum_next   = sum_reg + SW'(step_cnt_reg);
                    state_next = ST_RETURN;
                end else begin
                    phase_next    = phase_down;
                    dir           = stc_pkg::DIR_DOWN;
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_RETURN: begin
                if (s_data.top_hit) begin
                    if (round_reg >= ROUND_LAST) begin
                        avg_next      = avg_prod[RECIP_SHIFT +: CW];
                        over_cnt_next = '0;
                        state_next    = ST_OVER;
                    end else begin
                        round_next    = round_reg + 3'd1;
                        step_cnt_next = '0;
                        state_next    = ST_DOWN;
                    end
                end else begin
                    phase_next = phase_up;
                    dir        = stc_pkg::DIR_UP;
                end
            end
            ST_OVER: begin
                if (over_cnt_reg >= overshoot_steps_reg) begin
                    done_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    phase_next    = phase_up;
                    dir           = stc_pkg::DIR_UP;
                    over_cnt_next = over_cnt_reg + 1'b1;
                end
            end
            default: begin
                // resting states: idle, done and both errors
                if (s_data.start_request) begin
                    state_next    = ST_UP;
                    step_cnt_next = '0;
                    round_next    = '0;
                    sum_next      = '0;
                    over_cnt_next = '0;
                end
            end
        endcase

        unique case (state_next)
            ST_IDLE:   status = stc_pkg::STAT_IDLE;
            ST_DONE:   status = stc_pkg::STAT_DONE;
            ST_TOPERR: status = stc_pkg::STAT_TOPERR;
            ST_BOTERR: status = stc_pkg::STAT_BOTERR;
            default:   status = stc_pkg::STAT_BUSY;
        endcase

        result.step_dir      = dir;
        result.phase         = phase_next;
        result.status        = status;
        result.calibrated    = done_next;
        result.average_count = avg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            step_cnt_reg <= '0;
            round_reg    <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            over_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end else if (in_xfer) begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            step_cnt_reg <= step_cnt_next;
            round_reg    <= round_next;
            sum_reg      <= sum_next;
            avg_reg      <= avg_next;
            over_cnt_reg <= over_cnt_next;
            done_reg     <= done_next;
        end
    end

    // output register with skid: a new result lands in the skid slot only when
    // the output register is full and not being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_xfer) begin
                out_valid_reg  <= skid_valid_reg || in_xfer;
                skid_valid_reg <= 1'b0;
            end else if (in_xfer) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_xfer) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (in_xfer && out_valid_reg && !out_xfer) begin
            skid_reg <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> done_reg)
        else $error("done state reached without the calibrated flag");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= ROUND_LAST)
        else $error("round index beyond the last round");

    a_step_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.step_dir != 2'd3))
        else $error("invalid step direction in result");

endmodule

[verif/travel_checker.sv]
module travel_checker #(
    parameter int PHASES = 8,
    parameter int ROUNDS = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  stc_pkg::tick_in_t                  s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  stc_pkg::tick_out_t                 m_data,
    input  logic                               cfg_wen,
    input  logic [stc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                 mismatch_count,
    output int                                 pending_results,
    output logic                               at_rest
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = stc_pkg::COUNT_W;
    localparam int SW = stc_pkg::SUM_W;
    localparam int OW = stc_pkg::OVER_W;

    typedef enum logic [2:0] {
        CAL_IDLE, CAL_UP, CAL_DOWN, CAL_RETURN, CAL_OVER, CAL_DONE, CAL_TOPERR, CAL_BOTERR
    } cal_state_t;

    cal_state_t          cal_state;
    logic [2:0]          coil_idx;
    logic [CW-1:0]       travel_cnt;
    logic [2:0]          pass_idx;
    logic [SW-1:0]       travel_sum;
    logic [CW-1:0]       avg_travel;
    logic [OW-1:0]       extra_cnt;
    logic                calib_done;
    logic [CW-1:0]       step_limit;
    logic [OW-1:0]       extra_limit;
    stc_pkg::tick_out_t  expected_ticks[$];
    int                  fails = 0;

    assign mismatch_count = fails;

    function automatic logic [2:0] coil_after_up(input logic [2:0] idx);
        return (int'(idx) + 1 >= PHASES) ? 3'd0 : idx + 3'd1;
    endfunction

    // advances the calibration sequencer by one step tick
    function automatic stc_pkg::tick_out_t predict_tick(input stc_pkg::tick_in_t t);
        stc_pkg::tick_out_t r;
        r.step_dir = stc_pkg::DIR_NONE;
        case (cal_state)
            CAL_UP: begin
                if (travel_cnt >= step_limit) begin
                    cal_state = CAL_TOPERR;
                end else if (t.top_hit) begin
                    travel_cnt = '0;
                    cal_state  = CAL_DOWN;
                end else begin
                    coil_idx   = coil_after_up(coil_idx);
                    r.step_dir = stc_pkg::DIR_UP;
                    travel_cnt = travel_cnt + 1'b1;
                end
            end
            CAL_DOWN: begin
                if (travel_cnt >= step_limit) begin
                    cal_state = CAL_BOTERR;
                end else if (t.bottom_hit) begin
                    travel_sum = travel_sum + SW'(travel_cnt);
                    cal_state  = CAL_RETURN;
                end else begin
                    coil_idx   = (coil_idx == 3'd0 || int'(coil_idx) >= PHASES) ?
                                 3'(PHASES - 1) : coil_idx - 3'd1;
                    r.step_dir = stc_pkg::DIR_DOWN;
                    travel_cnt = travel_cnt + 1'b1;
                end
            end
            CAL_RETURN: begin
                if (t.top_hit) begin
                    if (int'(pass_idx) + 1 >= ROUNDS) begin
                        avg_travel = CW'(travel_sum / SW'(ROUNDS));
                        extra_cnt  = '0;
                        cal_state  = CAL_OVER;
                    end else begin
                        pass_idx   = pass_idx + 3'd1;
                        travel_cnt = '0;
                        cal_state  = CAL_DOWN;
                    end
                end else begin
                    coil_idx   = coil_after_up(coil_idx);
                    r.step_dir = stc_pkg::DIR_UP;
                end
            end
            CAL_OVER: begin
                if (extra_cnt >= extra_limit) begin
                    calib_done = 1'b1;
                    cal_state  = CAL_DONE;
                end else begin
                    coil_idx   = coil_after_up(coil_idx);
                    r.step_dir = stc_pkg::DIR_UP;
                    extra_cnt  = extra_cnt + 1'b1;
                end
            end
            default: begin
                // idle, done and both error states wait for a start
                if (t.start_request) begin
                    cal_state  = CAL_UP;
                    travel_cnt = '0;
                    pass_idx   = '0;
                    travel_sum = '0;
                    extra_cnt  = '0;
                end
            end
        endcase
        case (cal_state)
            CAL_IDLE:   r.status = stc_pkg::STAT_IDLE;
            CAL_DONE:   r.status = stc_pkg::STAT_DONE;
            CAL_TOPERR: r.status = stc_pkg::STAT_TOPERR;
            CAL_BOTERR: r.status = stc_pkg::STAT_BOTERR;
            default:    r.status = stc_pkg::STAT_BUSY;
        endcase
        r.phase         = coil_idx;
        r.calibrated    = calib_done;
        r.average_count = avg_travel;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [CW-1:0] want,
                                 input logic [CW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        stc_pkg::tick_out_t want;
        if (!aresetn) begin
            cal_state   = CAL_IDLE;
            coil_idx    = '0;
            travel_cnt  = '0;
            pass_idx    = '0;
            travel_sum  = '0;
            avg_travel  = '0;
            extra_cnt   = '0;
            calib_done  = 1'b0;
            step_limit  = stc_pkg::STEP_LIMIT_RESET;
            extra_limit = stc_pkg::OVERSHOOT_RESET;
            expected_ticks.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_field("step_dir", CW'(want.step_dir), CW'(m_data.step_dir));
                    compare_field("phase", CW'(want.phase), CW'(m_data.phase));
                    compare_field("status", CW'(want.status), CW'(m_data.status));
                    compare_field("calibrated", CW'(want.calibrated),
                                  CW'(m_data.calibrated));
                    compare_field("average_count", want.average_count,
                                  m_data.average_count);
                end
            end
            if (s_valid && s_ready)
                expected_ticks.push_back(predict_tick(s_data));
            // a register write counts from the next tick on
            if (cfg_wen) begin
                if (cfg_index == stc_pkg::CFG_STEP_LIMIT)
                    step_limit = cfg_wdata;
                else if (cfg_index == stc_pkg::CFG_OVERSHOOT)
                    extra_limit = cfg_wdata[OW-1:0];
            end
        end
        pending_results <= expected_ticks.size();
        at_rest <= (cal_state == CAL_IDLE || cal_state == CAL_DONE ||
                    cal_state == CAL_TOPERR || cal_state == CAL_BOTERR);
    end

endmodule

[verif/stepper_travel_calibrator_tb.sv]
module stepper_travel_calibrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES = 8;
    localparam int ROUNDS = 3;
    localparam int IW = stc_pkg::CFG_IDX_W;
    localparam int DW = stc_pkg::CFG_DATA_W;
    localparam int OW = stc_pkg::OVER_W;
    // nothing moves on either channel for this long: the block has hung
    localparam int STALL_LIMIT = 4096;

    localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    stc_pkg::tick_in_t     s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    stc_pkg::tick_out_t    m_data;
    logic                  cfg_wen   = 1'b0;
    logic [IW-1:0]         cfg_index = '0;
    logic [DW-1:0]         cfg_wdata = '0;

    int                    mismatch_count;
    int                    pending_results;
    logic                  at_rest;

    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    ticks_sent    = 0;
    int                    runs_made     = 0;
    int                    quiet_cycles  = 0;
    int                    cur_limit     = int'(stc_pkg::STEP_LIMIT_RESET);
    int                    cur_extra     = int'(stc_pkg::OVERSHOOT_RESET);

    always #5 aclk = ~aclk;

    stepper_travel_calibrator #(
        .PHASES (PHASES),
        .ROUNDS (ROUNDS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    travel_checker #(
        .PHASES (PHASES),
        .ROUNDS (ROUNDS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .at_rest         (at_rest)
    );

    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic coin_flip();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_tick(input logic start, input logic top, input logic bottom);
        stc_pkg::tick_in_t t;
        t.start_request = start;
        t.top_hit       = top;
        t.bottom_hit    = bottom;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_data  <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic write_regs(input logic [DW-1:0] limit, input logic [DW-1:0] extra);
        // registers change only once every result is back
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        cfg_wen   <= 1'b1;
        cfg_index <= stc_pkg::CFG_STEP_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_index <= stc_pkg::CFG_OVERSHOOT;
        cfg_wdata <= extra;
        @(posedge aclk);
        cfg_index <= CFG_SPARE_A;
        cfg_wdata <= DW'($urandom);
        @(posedge aclk);
        cfg_index <= CFG_SPARE_B;
        cfg_wdata <= DW'($urandom);
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        cur_limit = int'(limit);
        cur_extra = int'(extra[OW-1:0]);
    endtask

    // push the sequencer on with both switches made until it rests again
    task automatic return_to_rest();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!at_rest)
            send_tick(1'b0, 1'b1, 1'b1);
    endtask

    // search length: mostly inside the limit, now and then at or past it for limits of 16 or less
    function automatic int pick_len(input int limit);
        if (limit <= 16 && $urandom_range(7) == 0)
            return limit + $urandom_range(2);
        if (limit == 0)
            return 0;
        return $urandom_range((limit > 8) ? 7 : limit - 1);
    endfunction

    task automatic calibration_run();
        send_tick(1'b1, coin_flip(), coin_flip());
        repeat (pick_len(cur_limit)) send_tick(coin_flip(), 1'b0, coin_flip());
        send_tick(coin_flip(), 1'b1, coin_flip());
        repeat (ROUNDS) begin
            repeat (pick_len(cur_limit))
                send_tick(coin_flip(), coin_flip(), 1'b0);
            send_tick(coin_flip(), coin_flip(), 1'b1);
            repeat ($urandom_range(6)) send_tick(coin_flip(), 1'b0, coin_flip());
            send_tick(coin_flip(), 1'b1, coin_flip());
        end
        repeat (cur_extra + 1)
            send_tick(coin_flip(), coin_flip(), coin_flip());
        runs_made++;
    endtask

    task automatic random_phase(input int idle_pct, input int stall,
                                input logic [DW-1:0] limit,
                                input logic [DW-1:0] extra, input int ticks);
        int goal;
        return_to_rest();
        write_regs(limit, extra);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        goal          = ticks_sent + ticks;
        while (ticks_sent < goal) begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 5))
                    send_tick(coin_flip(), coin_flip(), coin_flip());
            calibration_run();
            return_to_rest();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // short run by hand, limit 3 and two overshoot steps
        write_regs(16'd3, 16'h7702);
        send_tick(1'b0, 1'b1, 1'b1);     // idle ignores the switches
        send_tick(1'b1, 1'b0, 1'b0);     // start tick, no step
        send_tick(1'b1, 1'b0, 1'b1);     // start while busy is ignored
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);     // phase wraps below zero
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);     // bottom straight away
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);     // last round, average taken
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);     // calibrated
        send_tick(1'b1, 1'b0, 1'b0);     // restart from done
        write_regs(16'd0, 16'h7702);     // limit dropped mid-run
        send_tick(1'b0, 1'b1, 1'b0);     // zero limit fails at once
        send_tick(1'b1, 1'b1, 1'b1);     // restart from top error
        write_regs(16'd1, 16'h7702);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);     // bottom error despite the switch
        send_tick(1'b1, 1'b0, 1'b0);     // restart from bottom error
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);

        random_phase(0, 0, 16'hFFFF, 16'hC304, 100);
        random_phase(53, 0, 16'd6, 16'h0000, 100);
        random_phase(0, 53, stc_pkg::STEP_LIMIT_RESET, {8'h5A, stc_pkg::OVERSHOOT_RESET}, 100);
        random_phase(19, 19, 16'd1, 16'h00FF, 100);

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (16) @(posedge aclk);

        $display("%0d ticks over %0d generated runs; step limits 0 to 65535, overshoot 0 to 255",
                 ticks_sent, runs_made);
        $display("idling on neither, either and both sides, with errors and restarts");
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
src/stc_pkg.sv
src/stepper_travel_calibrator.sv
verif/travel_checker.sv
verif/stepper_travel_calibrator_tb.sv
